### src/matrix_surround_encoder_unit_defines.svh
// Assertion helpers for the matrix surround encoder
`ifndef MATRIX_SURROUND_ENCODER_UNIT_DEFINES_SVH
`define MATRIX_SURROUND_ENCODER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a signal is quiet while reset is applied
`define MSE_ASSERT_RST(label, sig, msg) \
  label: assert property (@(posedge clk_i) !rst_ni |=> !(sig)) else $error(msg);

`endif

### src/mse_pkg.sv
package mse_pkg;

  localparam int unsigned DelayDepth = 8192;
  localparam int unsigned AddrW      = $clog2(DelayDepth);
  localparam int unsigned LenW       = 14;
  localparam int unsigned CoefW      = 13;
  localparam int unsigned SampW      = 32;
  localparam int unsigned EchoW      = 24;
  localparam int unsigned AccW       = 48;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 14;

  localparam logic [CfgIdxW-1:0] RegHpB0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHpB1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHpA1   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLpB0   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLpB1   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLpA1   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDelLen = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd7;

  localparam logic [1:0] ModeBypass = 2'd0;
  localparam logic [1:0] ModeStereo = 2'd1;
  localparam logic [1:0] ModeQuad   = 2'd2;

  typedef struct packed {
    logic signed [SampW-1:0] front_left;
    logic signed [SampW-1:0] front_right;
    logic signed [SampW-1:0] rear_left;
    logic signed [SampW-1:0] rear_right;
    logic                    block_last;
  } in_req_t;

  typedef struct packed {
    logic signed [SampW-1:0] out_front_left;
    logic signed [SampW-1:0] out_front_right;
    logic signed [SampW-1:0] out_rear_left;
    logic signed [SampW-1:0] out_rear_right;
    logic                    out_block_last;
  } out_req_t;

  // Control between the sequencer and the serial multiply-accumulate unit
  typedef struct packed {
    logic                    start;
    logic signed [SampW-1:0] mcand;
    logic signed [CoefW-1:0] coef;
    logic                    clear;
  } mac_ctl_t;

endpackage

### src/mse_mac.sv
// Digit-serial multiply-accumulate: the coefficient is consumed four bits per
// cycle, least significant digit first, the top digit carries the sign.
module mse_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mse_pkg::mac_ctl_t                     ctl_i,
  output logic                                  busy_o,
  output logic signed [mse_pkg::AccW-1:0]       acc_o
);

  localparam int unsigned NDig  = (mse_pkg::CoefW + mse_pkg::DigitW - 1) / mse_pkg::DigitW;
  localparam int unsigned CoefX = NDig * mse_pkg::DigitW;
  localparam int unsigned CntW  = $clog2(NDig + 1);

  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic [CoefX-1:0]                 sh_q, sh_d;
  logic signed [mse_pkg::AccW-1:0]  mc_q, mc_d;
  logic signed [mse_pkg::AccW-1:0]  acc_q, acc_d;
  logic signed [mse_pkg::DigitW:0]  dig;
  logic signed [mse_pkg::AccW-1:0]  part;

  // Top digit is signed, lower digits unsigned
  always_comb begin
    if (cnt_q == CntW'(1)) begin
      dig = {sh_q[mse_pkg::DigitW-1], sh_q[mse_pkg::DigitW-1:0]};
    end else begin
      dig = {1'b0, sh_q[mse_pkg::DigitW-1:0]};
    end
    part = mc_q * mse_pkg::AccW'(dig);
  end

  always_comb begin
    cnt_d = cnt_q;
    sh_d  = sh_q;
    mc_d  = mc_q;
    acc_d = acc_q;
    if (ctl_i.start) begin
      cnt_d = CntW'(NDig);
      sh_d  = CoefX'(ctl_i.coef);
      mc_d  = mse_pkg::AccW'(ctl_i.mcand);
      if (ctl_i.clear) acc_d = '0;
    end else if (cnt_q != '0) begin
      // Add one partial product and advance to the next digit
      acc_d = acc_q + part;
      mc_d  = mc_q <<< mse_pkg::DigitW;
      sh_d  = sh_q >> mse_pkg::DigitW;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    mc_q  <= mc_d;
    acc_q <= acc_d;
  end

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;

endmodule

### src/mse_delay.sv
// Circular delay store with one write and one registered read port
module mse_delay (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [mse_pkg::AddrW-1:0]           waddr_i,
  input  logic signed [mse_pkg::EchoW-1:0]    wdata_i,
  input  logic                                re_i,
  input  logic [mse_pkg::AddrW-1:0]           raddr_i,
  output logic signed [mse_pkg::EchoW-1:0]    rdata_o
);

  logic signed [mse_pkg::EchoW-1:0] mem_q [mse_pkg::DelayDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/matrix_surround_encoder_unit.sv
// Matrix surround encoder. One request in, one request out. Bypass requests
// go from acceptance straight to the output register; surround requests pass
// through the delay store and the filters first. Their time is set by six
// products through one shared 4-bit digit-serial multiplier, each a load and
// four digits. A result still stalled at the output holds the next one back.
// After reset the delay store is cleared one entry a cycle, all 8192 entries,
// and no input request is taken until that is done.
// An output register holds the result so the next request may be accepted
// while it waits.
`include "matrix_surround_encoder_unit_defines.svh"

module matrix_surround_encoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mse_pkg::in_req_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mse_pkg::out_req_t                     out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [mse_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [mse_pkg::CfgDataW-1:0]          cfg_data_i
);

  localparam int unsigned AW = mse_pkg::AddrW;
  localparam int unsigned SW = mse_pkg::SampW;
  localparam int unsigned EW = mse_pkg::EchoW;
  localparam int unsigned CW = mse_pkg::CoefW;
  localparam int unsigned LW = mse_pkg::LenW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_HP0, S_HP1, S_HP2, S_HPW, S_LP0, S_LP1, S_LP2,
    S_LPW, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic signed [CW-1:0] hp_b0_q, hp_b1_q, hp_a1_q, lp_b0_q, lp_b1_q, lp_a1_q;
  logic [LW-1:0]        len_q;
  logic [1:0]           mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_b0_q <= '0; hp_b1_q <= '0; hp_a1_q <= '0;
      lp_b0_q <= '0; lp_b1_q <= '0; lp_a1_q <= '0;
      len_q   <= LW'(1);
      mode_q  <= mse_pkg::ModeStereo;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mse_pkg::RegHpB0:   hp_b0_q <= cfg_data_i[CW-1:0];
        mse_pkg::RegHpB1:   hp_b1_q <= cfg_data_i[CW-1:0];
        mse_pkg::RegHpA1:   hp_a1_q <= cfg_data_i[CW-1:0];
        mse_pkg::RegLpB0:   lp_b0_q <= cfg_data_i[CW-1:0];
        mse_pkg::RegLpB1:   lp_b1_q <= cfg_data_i[CW-1:0];
        mse_pkg::RegLpA1:   lp_a1_q <= cfg_data_i[CW-1:0];
        mse_pkg::RegDelLen: len_q   <= cfg_data_i[LW-1:0];
        mse_pkg::RegMode:   mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Request and state registers
  mse_pkg::in_req_t      req_q;
  logic                  quad_q;
  logic [AW-1:0]         pos_q;
  logic [AW:0]           clr_q;
  logic signed [EW-1:0]  hpin_q;
  logic signed [SW-1:0]  hpout_q, lpout_q, v0_q, v_q;
  logic                  out_valid_q;
  mse_pkg::out_req_t     out_q;

  // Mono sum, computed from the held request
  logic signed [SW:0]    hl, hr;
  logic signed [SW+1:0]  msum;
  logic signed [EW-1:0]  mono24;
  always_comb begin
    hl = quad_q ? (SW+1)'(req_q.front_left >>> 1) : (SW+1)'(req_q.front_left);
    hr = quad_q ? (SW+1)'(req_q.front_right >>> 1) : (SW+1)'(req_q.front_right);
    msum = (SW+2)'(hl) + (SW+2)'(hr) + (SW+2)'(256);
    mono24 = EW'(msum >>> 9);
  end

  // Effective length and next position
  logic [LW-1:0] len_eff;
  logic [AW:0]   pos_inc;
  always_comb begin
    len_eff = len_q;
    if (len_q == '0) len_eff = LW'(1);
    if (len_q > LW'(mse_pkg::DelayDepth)) len_eff = LW'(mse_pkg::DelayDepth);
    pos_inc = {1'b0, pos_q} + (AW+1)'(1);
  end

  // Delay store
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa;
  logic signed [EW-1:0] mem_wd, echo;
  assign mem_we = (state_q == S_CLEAR) || (state_q == S_READ);
  assign mem_wa = (state_q == S_CLEAR) ? clr_q[AW-1:0] : pos_q;
  assign mem_wd = (state_q == S_CLEAR) ? '0 : mono24;
  assign mem_re = (state_q == S_READ);

  mse_delay u_delay (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (echo)
  );

  // Shared multiplier
  mse_pkg::mac_ctl_t         mac_ctl;
  logic                      mac_busy;
  logic signed [mse_pkg::AccW-1:0] acc;
  logic signed [SW-1:0]      v0_n, v_n;
  assign v0_n = SW'(acc >>> 10);
  assign v_n  = SW'(acc >>> 2);

  always_comb begin
    mac_ctl = '0;
    case (state_q)
      S_HP0: mac_ctl = '{1'b1, SW'(echo), hp_b0_q, 1'b1};
      S_HP1: mac_ctl = '{!mac_busy, SW'(hpin_q), hp_b1_q, 1'b0};
      S_HP2: mac_ctl = '{!mac_busy, hpout_q, hp_a1_q, 1'b0};
      S_LP0: mac_ctl = '{1'b1, v0_q, lp_b0_q, 1'b1};
      S_LP1: mac_ctl = '{!mac_busy, hpout_q, lp_b1_q, 1'b0};
      S_LP2: mac_ctl = '{!mac_busy, lpout_q, lp_a1_q, 1'b0};
      default: mac_ctl = '0;
    endcase
  end

  mse_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  logic in_acc, out_acc, out_free;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_acc;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer: hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      hpin_q      <= '0;
      hpout_q     <= '0;
      lpout_q     <= '0;
      out_valid_q <= 1'b0;
      quad_q      <= 1'b0;
    end else begin
      // Drop the taken result unless a new one is loaded in its place
      if (out_acc && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + (AW+1)'(1);
          if (clr_q == (AW+1)'(mse_pkg::DelayDepth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            quad_q <= mode_q[1];
            if (mode_q == mse_pkg::ModeBypass) begin
              v_q <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_HP0;
        S_HP0: state_q <= S_HP1;
        S_HP1: if (!mac_busy) state_q <= S_HP2;
        S_HP2: if (!mac_busy) state_q <= S_HPW;
        S_HPW: if (!mac_busy) begin
          v0_q <= v0_n;
          hpin_q <= echo;
          state_q <= S_LP0;
        end
        S_LP0: state_q <= S_LP1;
        S_LP1: if (!mac_busy) state_q <= S_LP2;
        S_LP2: if (!mac_busy) state_q <= S_LPW;
        S_LPW: if (!mac_busy) begin
          v_q <= v_n;
          hpout_q <= v0_q;
          lpout_q <= SW'(v_n >>> 8);
          pos_q <= (pos_inc >= (AW+1)'(len_eff)) ? '0 : pos_inc[AW-1:0];
          state_q <= S_OUT;
        end
        S_OUT: if (out_free) begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Latch the request and form the result
  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_data_i;
    if (state_q == S_OUT && out_free) begin
      out_q.out_block_last <= req_q.block_last;
      if (mode_q == mse_pkg::ModeBypass) begin
        out_q.out_front_left  <= req_q.front_left;
        out_q.out_front_right <= req_q.front_right;
        out_q.out_rear_left   <= req_q.rear_left;
        out_q.out_rear_right  <= req_q.rear_right;
      end else if (quad_q) begin
        out_q.out_front_left  <= req_q.front_left;
        out_q.out_front_right <= req_q.front_right;
        out_q.out_rear_left   <= req_q.rear_left + SW'(hl) + v_q;
        out_q.out_rear_right  <= req_q.rear_right + SW'(hr) + v_q;
      end else begin
        out_q.out_front_left  <= req_q.front_left + v_q;
        out_q.out_front_right <= req_q.front_right - v_q;
        out_q.out_rear_left   <= req_q.rear_left;
        out_q.out_rear_right  <= req_q.rear_right;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MSE_ASSERT(a_no_take_in_clear, (state_q == S_CLEAR) |-> in_stall_o, "input taken during clear")
  `MSE_ASSERT(a_hold_out, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped")
  `MSE_ASSERT(a_mac_idle_out, (state_q == S_OUT) |-> !mac_busy, "multiplier busy at output")
  `MSE_ASSERT_RST(a_rst_out, out_valid_o, "result valid in reset")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ModeAlias  = 2'd3;
  localparam int         SettleCyc  = 60;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  mse_pkg::in_req_t             in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  mse_pkg::out_req_t            out_data_o;
  logic                         cfg_we_i = 1'b0;
  logic [mse_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [mse_pkg::CfgDataW-1:0] cfg_data_i = '0;

  matrix_surround_encoder_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the encoder state and registers
  logic signed [mse_pkg::EchoW-1:0] echo_line [mse_pkg::DelayDepth];
  int unsigned                      wr_pos;
  logic signed [mse_pkg::EchoW-1:0] hp_last_in;
  logic signed [mse_pkg::SampW-1:0] hp_last_out;
  logic signed [mse_pkg::SampW-1:0] lp_last_out;
  longint                  c_hp_b0, c_hp_b1, c_hp_a1, c_lp_b0, c_lp_b1, c_lp_a1;
  int unsigned             dly_len;
  logic [1:0]              mode;

  mse_pkg::in_req_t  pending_reqs [$];
  mse_pkg::out_req_t awaited_outs [$];
  bit       calm = 1'b0;
  int       err_count = 0;
  int       req_count = 0;
  int       out_count = 0;

  // Work out the output request for one input request, advancing the state
  function automatic mse_pkg::out_req_t surround_predict(mse_pkg::in_req_t r);
    mse_pkg::out_req_t                o;
    longint                           fl, fr, rl, rr, hl, hr, mono, echo, acc;
    logic signed [mse_pkg::AccW-1:0]  a48;
    logic signed [mse_pkg::SampW-1:0] hp_v, sv;
    int unsigned                      len, pos;
    fl = longint'(r.front_left);
    fr = longint'(r.front_right);
    rl = longint'(r.rear_left);
    rr = longint'(r.rear_right);
    o.out_front_left  = r.front_left;
    o.out_front_right = r.front_right;
    o.out_rear_left   = r.rear_left;
    o.out_rear_right  = r.rear_right;
    o.out_block_last  = r.block_last;
    if (mode != mse_pkg::ModeBypass) begin
      if (mode[1]) begin
        hl = fl >>> 1;
        hr = fr >>> 1;
        mono = (hl + hr + 256) >>> 9;
      end else begin
        mono = (fl + fr + 256) >>> 9;
      end
      len = dly_len;
      if (len < 1) len = 1;
      if (len > mse_pkg::DelayDepth) len = mse_pkg::DelayDepth;
      pos = (wr_pos >= mse_pkg::DelayDepth) ? 0 : wr_pos;
      echo = echo_line[pos];
      echo_line[pos] = mono[mse_pkg::EchoW-1:0];
      // high-pass stage
      acc = c_hp_b0 * echo + c_hp_b1 * longint'(hp_last_in)
          + c_hp_a1 * longint'(hp_last_out);
      a48 = acc[mse_pkg::AccW-1:0];
      hp_v = mse_pkg::SampW'(a48 >>> 10);
      hp_last_in = echo[mse_pkg::EchoW-1:0];
      // low-pass stage
      acc = c_lp_b0 * longint'(hp_v) + c_lp_b1 * longint'(hp_last_out)
          + c_lp_a1 * longint'(lp_last_out);
      a48 = acc[mse_pkg::AccW-1:0];
      sv = mse_pkg::SampW'(a48 >>> 2);
      hp_last_out = hp_v;
      lp_last_out = sv >>> 8;
      if (mode[1]) begin
        o.out_rear_left  = mse_pkg::SampW'(rl + hl + longint'(sv));
        o.out_rear_right = mse_pkg::SampW'(rr + hr + longint'(sv));
      end else begin
        o.out_front_left  = mse_pkg::SampW'(fl + longint'(sv));
        o.out_front_right = mse_pkg::SampW'(fr - longint'(sv));
      end
      wr_pos = (pos + 1 >= len) ? 0 : pos + 1;
    end
    return o;
  endfunction

  // Drive requests from the pending queue, hold while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        awaited_outs.push_back(surround_predict(in_data_i));
        req_count++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          in_data_i  <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check output requests against the oldest prediction
  always @(posedge clk_i) begin
    mse_pkg::out_req_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        out_count++;
        if (awaited_outs.size() == 0) begin
          $error("output request with none expected");
          err_count++;
        end else begin
          e = awaited_outs.pop_front();
          if (out_data_o.out_front_left !== e.out_front_left) begin
            $error("out_front_left expected %0d got %0d", e.out_front_left,
                   out_data_o.out_front_left);
            err_count++;
          end
          if (out_data_o.out_front_right !== e.out_front_right) begin
            $error("out_front_right expected %0d got %0d", e.out_front_right,
                   out_data_o.out_front_right);
            err_count++;
          end
          if (out_data_o.out_rear_left !== e.out_rear_left) begin
            $error("out_rear_left expected %0d got %0d", e.out_rear_left,
                   out_data_o.out_rear_left);
            err_count++;
          end
          if (out_data_o.out_rear_right !== e.out_rear_right) begin
            $error("out_rear_right expected %0d got %0d", e.out_rear_right,
                   out_data_o.out_rear_right);
            err_count++;
          end
          if (out_data_o.out_block_last !== e.out_block_last) begin
            $error("out_block_last expected %0d got %0d", e.out_block_last,
                   out_data_o.out_block_last);
            err_count++;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 32);
    end
  end

  // Write one register and mirror it in the shadow copy
  task automatic reg_write(logic [mse_pkg::CfgIdxW-1:0] idx,
                           logic [mse_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      mse_pkg::RegHpB0:   c_hp_b0 = longint'(signed'(val[mse_pkg::CoefW-1:0]));
      mse_pkg::RegHpB1:   c_hp_b1 = longint'(signed'(val[mse_pkg::CoefW-1:0]));
      mse_pkg::RegHpA1:   c_hp_a1 = longint'(signed'(val[mse_pkg::CoefW-1:0]));
      mse_pkg::RegLpB0:   c_lp_b0 = longint'(signed'(val[mse_pkg::CoefW-1:0]));
      mse_pkg::RegLpB1:   c_lp_b1 = longint'(signed'(val[mse_pkg::CoefW-1:0]));
      mse_pkg::RegLpA1:   c_lp_a1 = longint'(signed'(val[mse_pkg::CoefW-1:0]));
      mse_pkg::RegDelLen: dly_len = 32'(val);
      mse_pkg::RegMode:   mode = val[1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_filters(int hb0, int hb1, int ha1, int lb0, int lb1, int la1);
    reg_write(mse_pkg::RegHpB0, mse_pkg::CfgDataW'(hb0));
    reg_write(mse_pkg::RegHpB1, mse_pkg::CfgDataW'(hb1));
    reg_write(mse_pkg::RegHpA1, mse_pkg::CfgDataW'(ha1));
    reg_write(mse_pkg::RegLpB0, mse_pkg::CfgDataW'(lb0));
    reg_write(mse_pkg::RegLpB1, mse_pkg::CfgDataW'(lb1));
    reg_write(mse_pkg::RegLpA1, mse_pkg::CfgDataW'(la1));
  endtask

  function automatic int rand_coef();
    case ($urandom_range(3))
      0: return $urandom_range(1024) + 512;
      1: return -int'($urandom_range(1024));
      2: return $urandom_range(1) ? -4096 : 4095;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return int'($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic mse_pkg::in_req_t rand_req();
    mse_pkg::in_req_t r;
    r.front_left  = rand_sample();
    r.front_right = rand_sample();
    r.rear_left   = rand_sample();
    r.rear_right  = rand_sample();
    r.block_last  = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_reqs.push_back(rand_req());
  endtask

  // Wait until every request has come back, then let the pipeline settle
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || awaited_outs.size() > 0)
      @(negedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic push_req(logic [31:0] fl, logic [31:0] fr, logic [31:0] rl,
                          logic [31:0] rr, logic bl);
    mse_pkg::in_req_t r;
    r.front_left  = fl;
    r.front_right = fr;
    r.rear_left   = rl;
    r.rear_right  = rr;
    r.block_last  = bl;
    pending_reqs.push_back(r);
  endtask

  initial begin
    for (int i = 0; i < mse_pkg::DelayDepth; i++) echo_line[i] = '0;
    wr_pos = 0;
    hp_last_in = '0;
    hp_last_out = '0;
    lp_last_out = '0;
    c_hp_b0 = 0; c_hp_b1 = 0; c_hp_a1 = 0;
    c_lp_b0 = 0; c_lp_b1 = 0; c_lp_a1 = 0;
    dly_len = 1;
    mode = mse_pkg::ModeStereo;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes with reset registers, then unity filters
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_req(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    push_req(32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    drain();
    set_filters(1024, -1024, 1000, 4095, 4095, -4096);
    reg_write(mse_pkg::RegDelLen, mse_pkg::CfgDataW'(3));
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h1234, 32'h5678, 1'b0);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
    push_req(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1, 1'b0);
    push_req(32'h100, 32'hff, 32'h0, 32'h0, 1'b0);
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
    drain();
    reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'(mse_pkg::ModeQuad));
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    push_req(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h1, 1'b0);
    drain();
    reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'(mse_pkg::ModeBypass));
    push_req(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff, 1'b1);
    push_req(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    drain();
    // Zero length behaves as one; the unused mode code behaves as quad
    reg_write(mse_pkg::RegDelLen, mse_pkg::CfgDataW'(0));
    reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'(ModeAlias));
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
    push_req(32'h1000, 32'h2000, 32'h3, 32'h4, 1'b0);
    drain();

    // Random with no idling on either side
    calm = 1'b1;
    set_filters(1024, -1000, 980, 300, 300, 400);
    reg_write(mse_pkg::RegDelLen, mse_pkg::CfgDataW'(5));
    reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'(mse_pkg::ModeStereo));
    queue_random(150);
    drain();
    calm = 1'b0;

    // Extreme coefficients, full-depth delay, quad
    set_filters(-4096, 4095, -4096, 4095, -4096, 4095);
    reg_write(mse_pkg::RegDelLen, mse_pkg::CfgDataW'(8192));
    reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'(mse_pkg::ModeQuad));
    queue_random(100);
    drain();

    // Length above the depth saturates
    reg_write(mse_pkg::RegDelLen, 14'h3fff);
    queue_random(60);
    drain();

    // Shorten the line below the current position
    reg_write(mse_pkg::RegDelLen, mse_pkg::CfgDataW'(100));
    reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'(mse_pkg::ModeStereo));
    queue_random(60);
    drain();
    reg_write(mse_pkg::RegDelLen, mse_pkg::CfgDataW'(7));
    queue_random(60);
    drain();

    // Random settings until the item budget is spent
    while (req_count < 1250) begin
      set_filters(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef());
      reg_write(mse_pkg::RegDelLen,
                mse_pkg::CfgDataW'(($urandom_range(7) == 0) ? $urandom_range(16383)
                                                            : $urandom_range(40)));
      reg_write(mse_pkg::RegMode, mse_pkg::CfgDataW'($urandom_range(3)));
      queue_random(80);
      drain();
    end

    if (awaited_outs.size() != 0) begin
      $error("%0d output requests never arrived", awaited_outs.size());
      err_count++;
    end
    $display("tb: %0d requests sent, %0d checked across bypass, stereo and quad",
             req_count, out_count);
    $display("tb: delay lengths 0 to 16383 and coefficient extremes exercised");
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

endmodule
